>>> src/bfp_pkg.sv
// ----------------------------------------------------------------------------
// bfp_pkg
// Shared types for the binary fraction period block: the datapath operation
// codes issued by the controller and the status returned by the datapath.
// ----------------------------------------------------------------------------
package bfp_pkg;

   localparam int unsigned VAL_W = 31;
   localparam int unsigned IDX_W = 6;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_GCD_DIV,
      OP_GCD_STEP,
      OP_RED_DIV,
      OP_RED_SET,
      OP_HALVE,
      OP_ONE,
      OP_TOT_INIT,
      OP_N_DIV,
      OP_TAKE_DM1,
      OP_TAKE_D,
      OP_NEXT_D,
      OP_TOT_FIN,
      OP_ORD_INIT,
      OP_REST_TAKE,
      OP_F_D,
      OP_F_N,
      OP_T_DIV,
      OP_PW_INIT,
      OP_MUL_RB,
      OP_MUL_BB,
      OP_MR_DIV,
      OP_SET_R,
      OP_SET_B,
      OP_ORD_TAKE,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic b_zero;
      logic rem_zero;
      logic m_even;
      logic m_one;
      logic d_ok;
      logic n_gt1;
      logic e_zero;
      logic e_odd;
      logic r_one;
   } stat_type;

endpackage

>>> src/binary_fraction_period_top.sv
// Each trial divisor costs one narrow division on the shared divider, and each
// modular square or product costs a wide reduction on the same divider.
// Throughput: one fraction at a time; the next beat is taken once the result is latched.
// Reset: synchronous, active high; clears the controller and the result valid flag.
// ----------------------------------------------------------------------------
// binary_fraction_period_top
// Preperiod index and period length of the binary expansion of a fraction.
// ----------------------------------------------------------------------------
module binary_fraction_period_top #(
   parameter int unsigned TRIAL_LIMIT = 46400
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // numerator [30:0], denominator [61:31], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // preperiod_index [5:0], period_length [36:6], zero pad
);

   bfp_pkg::cmd_type  cmd;
   bfp_pkg::stat_type stat;
   logic [bfp_pkg::IDX_W-1:0] preperiod_index;
   logic [bfp_pkg::VAL_W-1:0] period_length;

   bfp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bfp_dpath #(
      .TRIAL_LIMIT (TRIAL_LIMIT)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .numerator       (req_tdata[30:0]),
      .denominator     (req_tdata[61:31]),
      .stat            (stat),
      .preperiod_index (preperiod_index),
      .period_length   (period_length)
   );

   assign rsp_tdata = {3'b000, period_length, preperiod_index};

endmodule

>>> src/bfp_div.sv
// ----------------------------------------------------------------------------
// bfp_div
// Restoring divider, one quotient bit per cycle. Narrow mode divides a 31-bit
// dividend; wide mode reduces a 62-bit product.
// ----------------------------------------------------------------------------
module bfp_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            wide,
   input  logic [2*bfp_pkg::VAL_W-1:0]     dividend,
   input  logic [bfp_pkg::VAL_W-1:0]       divisor,
   output logic                            busy,
   output logic [bfp_pkg::VAL_W-1:0]       quo,
   output logic [bfp_pkg::VAL_W-1:0]       rem
);

   localparam int unsigned W  = bfp_pkg::VAL_W;
   localparam int unsigned CW = $clog2(2*W + 1);

   logic           busy_ff, busy_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [2*W-1:0] qr_ff, qr_in;
   logic [W-1:0]   rem_ff, rem_in;
   logic [W-1:0]   dvs_ff, dvs_in;
   logic [W:0]     trial;
   logic [W:0]     diff;
   logic           ge;

   assign trial = {rem_ff, qr_ff[2*W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      qr_in   = qr_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         dvs_in  = divisor;
         rem_in  = '0;
         if (wide) begin
            qr_in  = dividend;
            cnt_in = CW'(2*W);
         end else begin
            qr_in  = {dividend[W-1:0], {W{1'b0}}};
            cnt_in = CW'(W);
         end
      end else if (busy_ff) begin
         rem_in = ge ? diff[W-1:0] : trial[W-1:0];
         qr_in  = {qr_ff[2*W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      qr_ff  <= qr_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy = busy_ff;
   assign quo  = qr_ff[W-1:0];
   assign rem  = rem_ff;

   // The partial remainder never reaches the divisor while a division runs.
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < dvs_ff)
      else $error("divider remainder out of range");

   a_last_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff == CW'(1) && !start) |=> !busy_ff)
      else $error("divider ran past its last step");

endmodule

>>> src/bfp_dpath.sv
// ----------------------------------------------------------------------------
// bfp_dpath
// Datapath: working registers for gcd, totient and order search, one shared
// multiplier, a squarer for the trial bound, the shared divider and the result register.
// ----------------------------------------------------------------------------
module bfp_dpath #(
   parameter int unsigned TRIAL_LIMIT = 46400
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bfp_pkg::cmd_type              cmd,
   input  logic [bfp_pkg::VAL_W-1:0]     numerator,
   input  logic [bfp_pkg::VAL_W-1:0]     denominator,
   output bfp_pkg::stat_type             stat,
   output logic [bfp_pkg::IDX_W-1:0]     preperiod_index,
   output logic [bfp_pkg::VAL_W-1:0]     period_length
);

   localparam int unsigned W   = bfp_pkg::VAL_W;
   localparam int unsigned DW  = $clog2(TRIAL_LIMIT + 3);
   localparam int unsigned SQW = (2*DW > W) ? 2*DW : W;

   logic [W-1:0]           a_ff, a_in, b_ff, b_in, qin_ff, qin_in, m_ff, m_in;
   logic [W-1:0]           n_ff, n_in, t_ff, t_in, f_ff, f_in, cand_ff, cand_in;
   logic [W-1:0]           e_ff, e_in, r_ff, r_in, pb_ff, pb_in;
   logic [DW-1:0]          d_ff, d_in;
   logic [bfp_pkg::IDX_W-1:0] twos_ff, twos_in, pre_ff, pre_in;
   logic [W-1:0]           per_ff, per_in;
   logic [2*W-1:0]         prod_ff, prod_in;

   logic [W-1:0]   mul_x, mul_y;
   logic [2*W-1:0] mul_p;
   logic [SQW-1:0] dsq;
   logic [DW-1:0]  d_next;
   logic [W-1:0]   den_fix;

   logic           div_start, div_wide, div_busy;
   logic [2*W-1:0] div_dvd;
   logic [W-1:0]   div_dvs, div_quo, div_rem;

   assign den_fix = (denominator == '0) ? W'(1) : denominator;
   assign d_next  = (d_ff == DW'(2)) ? DW'(3) : d_ff + DW'(2);
   assign dsq     = SQW'(d_ff) * SQW'(d_ff);
   assign mul_p   = mul_x * mul_y;

   always_comb begin
      mul_x = t_ff;
      mul_y = W'(d_ff);
      unique case (cmd.op)
         bfp_pkg::OP_TAKE_DM1: mul_y = W'(d_ff - DW'(1));
         bfp_pkg::OP_TOT_FIN:  mul_y = n_ff - W'(1);
         bfp_pkg::OP_MUL_RB: begin
            mul_x = r_ff;
            mul_y = pb_ff;
         end
         bfp_pkg::OP_MUL_BB: begin
            mul_x = pb_ff;
            mul_y = pb_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      div_wide  = 1'b0;
      div_dvd   = {W'(0), n_ff};
      div_dvs   = W'(d_ff);
      unique case (cmd.op)
         bfp_pkg::OP_GCD_DIV: begin
            div_start = 1'b1;
            div_dvd   = {W'(0), a_ff};
            div_dvs   = b_ff;
         end
         bfp_pkg::OP_RED_DIV: begin
            div_start = 1'b1;
            div_dvd   = {W'(0), qin_ff};
            div_dvs   = a_ff;
         end
         bfp_pkg::OP_N_DIV: div_start = 1'b1;
         bfp_pkg::OP_T_DIV: begin
            div_start = 1'b1;
            div_dvd   = {W'(0), t_ff};
            div_dvs   = f_ff;
         end
         bfp_pkg::OP_MR_DIV: begin
            div_start = 1'b1;
            div_wide  = 1'b1;
            div_dvd   = prod_ff;
            div_dvs   = m_ff;
         end
         default: begin
         end
      endcase
   end

   bfp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .wide     (div_wide),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .busy     (div_busy),
      .quo      (div_quo),
      .rem      (div_rem)
   );

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      qin_in  = qin_ff;
      m_in    = m_ff;
      n_in    = n_ff;
      t_in    = t_ff;
      f_in    = f_ff;
      cand_in = cand_ff;
      e_in    = e_ff;
      r_in    = r_ff;
      pb_in   = pb_ff;
      d_in    = d_ff;
      twos_in = twos_ff;
      pre_in  = pre_ff;
      per_in  = per_ff;
      prod_in = prod_ff;
      unique case (cmd.op)
         bfp_pkg::OP_LOAD: begin
            a_in    = numerator;
            b_in    = den_fix;
            qin_in  = den_fix;
            twos_in = '0;
         end
         bfp_pkg::OP_GCD_STEP: begin
            a_in = b_ff;
            b_in = div_rem;
         end
         bfp_pkg::OP_RED_SET: m_in = div_quo;
         bfp_pkg::OP_HALVE: begin
            m_in    = {1'b0, m_ff[W-1:1]};
            twos_in = twos_ff + bfp_pkg::IDX_W'(1);
         end
         bfp_pkg::OP_ONE: t_in = W'(1);
         bfp_pkg::OP_TOT_INIT: begin
            n_in = m_ff;
            t_in = W'(1);
            d_in = DW'(2);
         end
         bfp_pkg::OP_TAKE_DM1, bfp_pkg::OP_TAKE_D: begin
            n_in = div_quo;
            t_in = mul_p[W-1:0];
         end
         bfp_pkg::OP_NEXT_D:   d_in = d_next;
         bfp_pkg::OP_TOT_FIN:  t_in = mul_p[W-1:0];
         bfp_pkg::OP_ORD_INIT: begin
            n_in = t_ff;
            d_in = DW'(2);
         end
         bfp_pkg::OP_REST_TAKE: n_in = div_quo;
         bfp_pkg::OP_F_D:       f_in = W'(d_ff);
         bfp_pkg::OP_F_N:       f_in = n_ff;
         bfp_pkg::OP_PW_INIT: begin
            cand_in = div_quo;
            e_in    = div_quo;
            r_in    = W'(1);
            pb_in   = W'(2);
         end
         bfp_pkg::OP_MUL_RB, bfp_pkg::OP_MUL_BB: prod_in = mul_p;
         bfp_pkg::OP_SET_R: r_in = div_rem;
         bfp_pkg::OP_SET_B: begin
            pb_in = div_rem;
            e_in  = {1'b0, e_ff[W-1:1]};
         end
         bfp_pkg::OP_ORD_TAKE: t_in = cand_ff;
         bfp_pkg::OP_EMIT: begin
            pre_in = twos_ff + bfp_pkg::IDX_W'(1);
            per_in = t_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      qin_ff  <= qin_in;
      m_ff    <= m_in;
      n_ff    <= n_in;
      t_ff    <= t_in;
      f_ff    <= f_in;
      cand_ff <= cand_in;
      e_ff    <= e_in;
      r_ff    <= r_in;
      pb_ff   <= pb_in;
      d_ff    <= d_in;
      twos_ff <= twos_in;
      pre_ff  <= pre_in;
      per_ff  <= per_in;
      prod_ff <= prod_in;
   end

   assign stat.div_busy = div_busy;
   assign stat.b_zero   = (b_ff == '0);
   assign stat.rem_zero = (div_rem == '0);
   assign stat.m_even   = ~m_ff[0];
   assign stat.m_one    = (m_ff == W'(1));
   assign stat.d_ok     = (d_ff <= DW'(TRIAL_LIMIT)) && (dsq <= SQW'(n_ff));
   assign stat.n_gt1    = (n_ff > W'(1));
   assign stat.e_zero   = (e_ff == '0);
   assign stat.e_odd    = e_ff[0];
   assign stat.r_one    = (r_ff == W'(1));

   assign preperiod_index = pre_ff;
   assign period_length   = per_ff;

   // The totient search starts only on an odd modulus.
   a_m_odd: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == bfp_pkg::OP_TOT_INIT) |-> m_ff[0])
      else $error("modulus still even at totient start");

   // A modular product is always reduced below the modulus.
   a_r_reduced: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == bfp_pkg::OP_SET_R) |=> (r_ff < m_ff))
      else $error("modular product not reduced");

endmodule

>>> src/bfp_ctrl.sv
// ----------------------------------------------------------------------------
// bfp_ctrl
// Controller: sequences gcd reduction, stripping of twos, the totient and
// the order search, and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module bfp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  bfp_pkg::stat_type stat,
   output bfp_pkg::cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_GCD, S_GCD_W, S_RED_W, S_STRIP, S_TOT, S_TOT_W, S_TOT_I,
      S_ORDI, S_ORD, S_ORD_W, S_RST, S_RST_W, S_SH, S_SH_W, S_PW, S_RB_D,
      S_RB_W, S_PBB, S_BB_D, S_BB_W, S_CHK, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      inner_ff, inner_in;
   logic      tail_ff, tail_in;
   logic      valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      inner_in = inner_ff;
      tail_in  = tail_ff;
      valid_in = valid_ff && !rsp_tready;
      cmd.op   = bfp_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = bfp_pkg::OP_LOAD;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (stat.b_zero) begin
               cmd.op   = bfp_pkg::OP_RED_DIV;
               state_in = S_RED_W;
            end else begin
               cmd.op   = bfp_pkg::OP_GCD_DIV;
               state_in = S_GCD_W;
            end
         end
         S_GCD_W: begin
            if (!stat.div_busy) begin
               cmd.op   = bfp_pkg::OP_GCD_STEP;
               state_in = S_GCD;
            end
         end
         S_RED_W: begin
            if (!stat.div_busy) begin
               cmd.op   = bfp_pkg::OP_RED_SET;
               state_in = S_STRIP;
            end
         end
         S_STRIP: begin
            priority if (stat.m_even) begin
               cmd.op = bfp_pkg::OP_HALVE;
            end else if (stat.m_one) begin
               cmd.op   = bfp_pkg::OP_ONE;
               state_in = S_EMIT;
            end else begin
               cmd.op   = bfp_pkg::OP_TOT_INIT;
               state_in = S_TOT;
            end
         end
         S_TOT: begin
            inner_in = 1'b0;
            if (stat.d_ok) begin
               cmd.op   = bfp_pkg::OP_N_DIV;
               state_in = S_TOT_W;
            end else begin
               // A cofactor left after trial division is prime.
               if (stat.n_gt1) begin
                  cmd.op = bfp_pkg::OP_TOT_FIN;
               end
               state_in = S_ORDI;
            end
         end
         S_TOT_W: begin
            if (!stat.div_busy) begin
               if (stat.rem_zero) begin
                  cmd.op   = inner_ff ? bfp_pkg::OP_TAKE_D : bfp_pkg::OP_TAKE_DM1;
                  inner_in = 1'b1;
                  state_in = S_TOT_I;
               end else begin
                  cmd.op   = bfp_pkg::OP_NEXT_D;
                  state_in = S_TOT;
               end
            end
         end
         S_TOT_I: begin
            cmd.op   = bfp_pkg::OP_N_DIV;
            state_in = S_TOT_W;
         end
         S_ORDI: begin
            cmd.op   = bfp_pkg::OP_ORD_INIT;
            state_in = S_ORD;
         end
         S_ORD: begin
            priority if (stat.d_ok) begin
               cmd.op   = bfp_pkg::OP_N_DIV;
               state_in = S_ORD_W;
            end else if (stat.n_gt1) begin
               cmd.op   = bfp_pkg::OP_F_N;
               tail_in  = 1'b1;
               state_in = S_SH;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_ORD_W: begin
            if (!stat.div_busy) begin
               if (stat.rem_zero) begin
                  cmd.op   = bfp_pkg::OP_F_D;
                  state_in = S_RST;
               end else begin
                  cmd.op   = bfp_pkg::OP_NEXT_D;
                  state_in = S_ORD;
               end
            end
         end
         S_RST: begin
            cmd.op   = bfp_pkg::OP_N_DIV;
            state_in = S_RST_W;
         end
         S_RST_W: begin
            if (!stat.div_busy) begin
               if (stat.rem_zero) begin
                  cmd.op   = bfp_pkg::OP_REST_TAKE;
                  state_in = S_RST;
               end else begin
                  tail_in  = 1'b0;
                  state_in = S_SH;
               end
            end
         end
         S_SH: begin
            cmd.op   = bfp_pkg::OP_T_DIV;
            state_in = S_SH_W;
         end
         S_SH_W: begin
            if (!stat.div_busy) begin
               priority if (stat.rem_zero) begin
                  cmd.op   = bfp_pkg::OP_PW_INIT;
                  state_in = S_PW;
               end else if (tail_ff) begin
                  state_in = S_EMIT;
               end else begin
                  cmd.op   = bfp_pkg::OP_NEXT_D;
                  state_in = S_ORD;
               end
            end
         end
         S_PW: begin
            priority if (stat.e_zero) begin
               state_in = S_CHK;
            end else if (stat.e_odd) begin
               cmd.op   = bfp_pkg::OP_MUL_RB;
               state_in = S_RB_D;
            end else begin
               cmd.op   = bfp_pkg::OP_MUL_BB;
               state_in = S_BB_D;
            end
         end
         S_RB_D: begin
            cmd.op   = bfp_pkg::OP_MR_DIV;
            state_in = S_RB_W;
         end
         S_RB_W: begin
            if (!stat.div_busy) begin
               cmd.op   = bfp_pkg::OP_SET_R;
               state_in = S_PBB;
            end
         end
         S_PBB: begin
            cmd.op   = bfp_pkg::OP_MUL_BB;
            state_in = S_BB_D;
         end
         S_BB_D: begin
            cmd.op   = bfp_pkg::OP_MR_DIV;
            state_in = S_BB_W;
         end
         S_BB_W: begin
            if (!stat.div_busy) begin
               cmd.op   = bfp_pkg::OP_SET_B;
               state_in = S_PW;
            end
         end
         S_CHK: begin
            priority if (stat.r_one) begin
               cmd.op   = bfp_pkg::OP_ORD_TAKE;
               state_in = S_SH;
            end else if (tail_ff) begin
               state_in = S_EMIT;
            end else begin
               cmd.op   = bfp_pkg::OP_NEXT_D;
               state_in = S_ORD;
            end
         end
         S_EMIT: begin
            if (!valid_ff || rsp_tready) begin
               cmd.op   = bfp_pkg::OP_EMIT;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         inner_ff <= 1'b0;
         tail_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         inner_ff <= inner_in;
         tail_ff  <= tail_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == bfp_pkg::OP_EMIT) |=> valid_ff)
      else $error("result beat not raised after emit");

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for binary_fraction_period_top. Each fraction beat is
// predicted in the bench: the preperiod index and the multiplicative order of
// two modulo the odd part of the reduced denominator. A directed set is
// followed by random fractions with random idling on both channels, a drain pause and a tail without idling.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TRIAL_LIMIT = 46400;
   localparam longint unsigned CYCLE_LIMIT = 40_000_000;

   typedef struct {
      logic [5:0]  index;
      logic [30:0] period;
   } shape_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // numerator [30:0], denominator [61:31], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // preperiod_index [5:0], period_length [36:6], zero pad

   shape_type       shape_queue[$];
   int              error_count = 0;
   longint unsigned cycle_count = 0;
   bit              quiet = 1'b0;

   binary_fraction_period_top #(.TRIAL_LIMIT(TRIAL_LIMIT)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned pow2_mod(longint unsigned e, longint unsigned m);
      longint unsigned r;
      longint unsigned b;
      r = 1 % m;
      b = 2 % m;
      while (e > 0) begin
         if (e[0]) r = (r * b) % m;
         b = (b * b) % m;
         e = e >> 1;
      end
      return r;
   endfunction

   function automatic longint unsigned euler_phi(longint unsigned n);
      longint unsigned t;
      longint unsigned d;
      t = 1;
      d = 2;
      while (d <= TRIAL_LIMIT && d * d <= n) begin
         if (n % d == 0) begin
            n = n / d;
            t = t * (d - 1);
            while (n % d == 0) begin
               n = n / d;
               t = t * d;
            end
         end
         d = (d == 2) ? 3 : d + 2;
      end
      if (n > 1) t = t * (n - 1);
      return t;
   endfunction

   function automatic longint unsigned strip_factor(longint unsigned ord, longint unsigned f,
                                                    longint unsigned m);
      while (ord % f == 0 && pow2_mod(ord / f, m) == 1) ord = ord / f;
      return ord;
   endfunction

   function automatic longint unsigned order_of_two(longint unsigned m);
      longint unsigned ord;
      longint unsigned rest;
      longint unsigned d;
      ord = euler_phi(m);
      rest = ord;
      d = 2;
      while (d <= TRIAL_LIMIT && d * d <= rest) begin
         if (rest % d == 0) begin
            while (rest % d == 0) rest = rest / d;
            ord = strip_factor(ord, d, m);
         end
         d = (d == 2) ? 3 : d + 2;
      end
      if (rest > 1) ord = strip_factor(ord, rest, m);
      return ord;
   endfunction

   function automatic shape_type fraction_shape(logic [30:0] num, logic [30:0] den);
      longint unsigned a;
      longint unsigned b;
      longint unsigned t;
      longint unsigned odd_part;
      int unsigned     twos;
      shape_type       s;
      a = num;
      b = (den == 0) ? 1 : den;
      odd_part = b;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      odd_part = odd_part / a;
      twos = 0;
      while (!odd_part[0]) begin
         odd_part = odd_part >> 1;
         twos++;
      end
      s.index = 6'(twos + 1);
      s.period = (odd_part == 1) ? 31'd1 : 31'(order_of_two(odd_part));
      return s;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("tb: mismatch %s got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // The request stays up after a beat until the next one is driven or a gap starts.
   task automatic idle_burst();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
   endtask

   task automatic send_fraction(logic [30:0] num, logic [30:0] den);
      idle_burst();
      req_tdata <= {2'b00, den, num};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      shape_queue = {shape_queue, fraction_shape(num, den)};
      @(negedge clock);
   endtask

   // Result stall driver.
   initial begin
      @(negedge clock);
      forever begin
         if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      shape_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (shape_queue.size() == 0) begin
            report_mismatch("unexpected beat, index", rsp_tdata[5:0], 0);
         end else begin
            want = shape_queue.pop_front();
            if (rsp_tdata[5:0] !== want.index)
               report_mismatch("preperiod_index", rsp_tdata[5:0], want.index);
            if (rsp_tdata[36:6] !== want.period)
               report_mismatch("period_length", rsp_tdata[36:6], want.period);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // Random denominator whose odd part stays small so the trial loops are short,
   // while shifts carry set bits up to the top of the field.
   function automatic logic [30:0] random_denominator();
      logic [30:0] odd;
      int unsigned shift;
      case ($urandom_range(0, 3))
         0: return 31'(1) << $urandom_range(0, 30);
         1: return 31'($urandom_range(1, 255));
         default: begin
            odd = 31'($urandom_range(0, 2047) * 2 + 1);
            shift = $urandom_range(0, 19);
            return odd << shift;
         end
      endcase
   endfunction

   task automatic test_directed();
      send_fraction(31'd0, 31'd12345);         // zero numerator
      send_fraction(31'd5, 31'd0);             // zero denominator acts as one
      send_fraction(31'd1, 31'd1);
      send_fraction(31'd1, 31'd3);
      send_fraction(31'd1, 31'd7);
      send_fraction(31'd3, 31'd6);
      send_fraction(31'd1, 31'd10);
      send_fraction(31'd7, 31'd7);
      send_fraction(31'd1, 31'd1 << 30);       // largest preperiod index
      send_fraction(31'h7FFF_FFFF, 31'd1 << 30);
      send_fraction(31'd1, 31'd9);
      send_fraction(31'd1, 31'd341);           // composite where two has small order
      send_fraction(31'd2, 31'd2 * 31'd1023);
      send_fraction(31'h7FFF_FFFF, 31'd3 << 29);
      send_fraction(31'd1, 31'd65537);         // prime cofactor after trial loop
      send_fraction(31'h5555_5555, 31'h2AAA_AAAA);
      send_fraction(31'd1, 31'h7FFF_FFFF);     // largest denominator, a prime
      send_fraction(31'h7FFF_FFFF, 31'h7FFF_FFFF);
   endtask

   task automatic test_random(int unsigned count);
      repeat (count) send_fraction(31'($urandom), random_denominator());
   endtask

   task automatic test_drain_pause();
      req_tvalid <= 1'b0;
      while (shape_queue.size() != 0) @(negedge clock);
      send_fraction(31'($urandom), random_denominator());
   endtask

   task automatic test_quiet_tail(int unsigned count);
      quiet = 1'b1;
      test_random(count);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(50);
      test_drain_pause();
      test_random(30);
      test_quiet_tail(20);
      req_tvalid <= 1'b0;
      while (shape_queue.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (error_count == 0 && shape_queue.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end
endmodule
